// ===== design/emr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// emr_pkg
// Shared widths, register indexes and defaults of the maze row generator.
// ----------------------------------------------------------------------------
package emr_pkg;

   localparam int DATA_W       = 64;
   localparam int LBL_W        = 13;
   localparam int CSR_W        = 7;
   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;

   localparam logic [CSR_W-1:0] ROW_COUNT_RST = 7'd2;
   localparam logic [CSR_W-1:0] COL_COUNT_RST = 7'd64;

   typedef enum logic {
      REG_ROW_COUNT = 1'b0,
      REG_COL_COUNT = 1'b1
   } reg_idx_type;

endpackage

// ===== design/eller_maze_row_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eller_maze_row_generator_unit
// Builds one maze row per request beat with Eller's scheme; set labels are
// kept in a label memory that is read, modified and written back.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries two random words (right and bottom decisions); each
//   accepted beat yields one rsp beat with the row's right and bottom walls and
//   a last-row flag. The csr port sets rows per maze and columns per row; write
//   it only while the unit is idle.
//   One row is processed at a time. With C columns in use, a row takes an
//   init pass (all MAX_COLS entries on the first row of a maze, C otherwise),
//   a right-wall pass with one label sweep per set merge, and one open-cell
//   count per bottom attempt; the last row adds another right-wall pass.
//   Each merge and each open-cell count sweeps the C label entries in use:
//   each entry is read, then a merge writes it back if it holds the old set.
//   The first row of every maze rewrites the whole label memory, so no
//   clearing pass is needed after reset.
//   Reset returns the registers to two rows and 64 columns and starts a new
//   maze. A finished row waits in the output register while rsp_stall is high;
//   the next request is taken once the finished row has moved into that register.
// ----------------------------------------------------------------------------
module eller_maze_row_generator_unit #(
   parameter int MAX_COLS = emr_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = emr_pkg::MAX_ROWS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [emr_pkg::DATA_W-1:0]  req_right_random,
   input  logic [emr_pkg::DATA_W-1:0]  req_bottom_random,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [emr_pkg::DATA_W-1:0]  rsp_right_walls,
   output logic [emr_pkg::DATA_W-1:0]  rsp_bottom_walls,
   output logic                        rsp_last_row,
   input  logic                        csr_we,
   input  emr_pkg::reg_idx_type        csr_index,
   input  logic [emr_pkg::CSR_W-1:0]   csr_wdata
);
   import emr_pkg::*;

   localparam int CW  = $clog2(MAX_COLS);
   localparam int NW  = CW + 1;
   localparam int RIW = $clog2(MAX_ROWS);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_RC_RD, S_RC_EX, S_RN_RD, S_RN_EX, S_M_RD, S_M_EX,
      S_BS, S_BI_RD, S_BI_EX, S_BC_RD, S_BC_EX, S_DONE
   } state_type;

   logic [LBL_W-1:0] lab_mem [MAX_COLS];
   logic [LBL_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [LBL_W-1:0] mem_wd;

   state_type        state_ff, state_in;
   logic [NW-1:0]    i_ff, i_in, j_ff, j_in, cols_ff, cols_in;
   logic [LBL_W-1:0] cur_ff, cur_in, from_ff, from_in, nl_ff, nl_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             lastph_ff, lastph_in, last_ff, last_in, row0_ff, row0_in;
   logic [MAX_COLS-1:0] rr_ff, rr_in, br_ff, br_in, rw_ff, rw_in, bw_ff, bw_in;
   logic [MAX_COLS-1:0] prior_ff, prior_in;
   logic [RIW-1:0]   row_ff, row_in;
   logic [CSR_W-1:0] row_count_ff, row_count_in, col_count_ff, col_count_in;
   logic             rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [DATA_W-1:0] rsp_right_ff, rsp_right_in, rsp_bottom_ff, rsp_bottom_in;

   logic [CSR_W-1:0] cols_c;
   logic [31:0]      rows_c;
   logic             last_c;
   logic [MAX_COLS-1:0] mask_c, top_c;
   logic             adv, merge_c, hit_c;
   logic [1:0]       cnt_n;

   always_ff @(posedge clock) begin
      rd_data_ff <= lab_mem[j_ff[CW-1:0]];
      if (mem_we) begin
         lab_mem[j_ff[CW-1:0]] <= mem_wd;
      end
   end

   always_comb begin
      cols_c = (col_count_ff == '0) ? CSR_W'(1) :
               ((32'(col_count_ff) > MAX_COLS) ? CSR_W'(MAX_COLS) : col_count_ff);
      rows_c = (row_count_ff < CSR_W'(2)) ? 32'd2 :
               ((32'(row_count_ff) > MAX_ROWS) ? 32'(MAX_ROWS) : 32'(row_count_ff));
      last_c = (32'(row_ff) + 32'd1) >= rows_c;
      for (int k = 0; k < MAX_COLS; k++) begin
         mask_c[k] = NW'(k) < cols_ff;
         top_c[k]  = NW'(k) == NW'(cols_ff - NW'(1));
      end
   end

   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      cols_in       = cols_ff;
      cur_in        = cur_ff;
      from_in       = from_ff;
      nl_in         = nl_ff;
      cnt_in        = cnt_ff;
      lastph_in     = lastph_ff;
      last_in       = last_ff;
      row0_in       = row0_ff;
      rr_in         = rr_ff;
      br_in         = br_ff;
      rw_in         = rw_ff;
      bw_in         = bw_ff;
      prior_in      = prior_ff;
      row_in        = row_ff;
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_bottom_in = rsp_bottom_ff;
      mem_we        = 1'b0;
      mem_wd        = cur_ff;
      adv           = 1'b0;
      merge_c       = 1'b0;
      hit_c         = 1'b0;
      cnt_n         = cnt_ff;

      if (csr_we) begin
         case (csr_index)
            REG_ROW_COUNT: row_count_in = csr_wdata;
            REG_COL_COUNT: col_count_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rr_in    = req_right_random[MAX_COLS-1:0];
               br_in    = req_bottom_random[MAX_COLS-1:0];
               cols_in  = cols_c[NW-1:0];
               last_in  = last_c;
               row0_in  = row_ff == '0;
               rw_in    = '0;
               bw_in    = '0;
               j_in     = '0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            if (row0_ff) begin
               mem_we = 1'b1;
               if (j_ff < cols_ff) begin
                  mem_wd = nl_ff;
                  nl_in  = nl_ff + LBL_W'(1);
               end else begin
                  mem_wd = '0;
               end
            end else if (prior_ff[j_ff[CW-1:0]]) begin
               mem_we = 1'b1;
               mem_wd = nl_ff;
               nl_in  = nl_ff + LBL_W'(1);
            end
            if ((row0_ff && j_ff == NW'(MAX_COLS - 1)) ||
                (!row0_ff && NW'(j_ff + NW'(1)) >= cols_ff)) begin
               if (cols_ff >= NW'(2)) begin
                  lastph_in = 1'b0;
                  j_in      = '0;
                  state_in  = S_RC_RD;
               end else begin
                  i_in     = '0;
                  state_in = S_BS;
               end
            end else begin
               j_in = j_ff + NW'(1);
            end
         end
         S_RC_RD: state_in = S_RC_EX;
         S_RC_EX: begin
            cur_in   = rd_data_ff;
            i_in     = '0;
            j_in     = NW'(1);
            state_in = S_RN_RD;
         end
         S_RN_RD: state_in = S_RN_EX;
         S_RN_EX: begin
            merge_c = lastph_ff ? (cur_ff != rd_data_ff) :
                      !(rr_ff[i_ff[CW-1:0]] || cur_ff == rd_data_ff);
            if (!lastph_ff && !merge_c) begin
               rw_in[i_ff[CW-1:0]] = 1'b1;
            end
            if (lastph_ff && merge_c) begin
               rw_in[i_ff[CW-1:0]] = 1'b0;
            end
            if (merge_c) begin
               from_in  = rd_data_ff;
               j_in     = '0;
               state_in = S_M_RD;
            end else begin
               cur_in = rd_data_ff;
               adv    = 1'b1;
            end
         end
         S_M_RD: state_in = S_M_EX;
         S_M_EX: begin
            if (rd_data_ff == from_ff) begin
               mem_we = 1'b1;
               mem_wd = cur_ff;
            end
            if (NW'(j_ff + NW'(1)) >= cols_ff) begin
               adv = 1'b1;
            end else begin
               j_in     = j_ff + NW'(1);
               state_in = S_M_RD;
            end
         end
         S_BS: begin
            if (i_ff >= cols_ff) begin
               if (last_ff && cols_ff >= NW'(2)) begin
                  lastph_in = 1'b1;
                  j_in      = '0;
                  state_in  = S_RC_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else if (br_ff[i_ff[CW-1:0]]) begin
               j_in     = i_ff;
               state_in = S_BI_RD;
            end else begin
               i_in = i_ff + NW'(1);
            end
         end
         S_BI_RD: state_in = S_BI_EX;
         S_BI_EX: begin
            from_in  = rd_data_ff;
            j_in     = '0;
            cnt_in   = '0;
            state_in = S_BC_RD;
         end
         S_BC_RD: state_in = S_BC_EX;
         S_BC_EX: begin
            hit_c = (rd_data_ff == from_ff) && !bw_ff[j_ff[CW-1:0]];
            cnt_n = hit_c ? ((cnt_ff == 2'd0) ? 2'd1 : 2'd2) : cnt_ff;
            if (NW'(j_ff + NW'(1)) >= cols_ff) begin
               if (cnt_n == 2'd2) begin
                  bw_in[i_ff[CW-1:0]] = 1'b1;
               end
               i_in     = i_ff + NW'(1);
               state_in = S_BS;
            end else begin
               cnt_in   = cnt_n;
               j_in     = j_ff + NW'(1);
               state_in = S_BC_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_last_in   = last_ff;
               rsp_right_in  = DATA_W'((rw_ff & mask_c) | top_c);
               rsp_bottom_in = DATA_W'(last_ff ? mask_c : bw_ff);
               if (last_ff) begin
                  row_in   = '0;
                  nl_in    = LBL_W'(1);
                  prior_in = '0;
               end else begin
                  row_in   = row_ff + RIW'(1);
                  prior_in = bw_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (adv) begin
         i_in = i_ff + NW'(1);
         if (NW'(i_ff + NW'(2)) < cols_ff) begin
            j_in     = NW'(i_ff + NW'(2));
            state_in = S_RN_RD;
         end else if (lastph_ff) begin
            state_in = S_DONE;
         end else begin
            i_in     = '0;
            state_in = S_BS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
         nl_ff        <= LBL_W'(1);
         prior_ff     <= '0;
         row_count_ff <= ROW_COUNT_RST;
         col_count_ff <= COL_COUNT_RST;
         lastph_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
         nl_ff        <= nl_in;
         prior_ff     <= prior_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         lastph_ff    <= lastph_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      cols_ff       <= cols_in;
      cur_ff        <= cur_in;
      from_ff       <= from_in;
      cnt_ff        <= cnt_in;
      last_ff       <= last_in;
      row0_ff       <= row0_in;
      rr_ff         <= rr_in;
      br_ff         <= br_in;
      rw_ff         <= rw_in;
      bw_ff         <= bw_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_bottom_ff <= rsp_bottom_in;
   end

   assign req_stall        = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_right_walls  = rsp_right_ff;
   assign rsp_bottom_walls = rsp_bottom_ff;
   assign rsp_last_row     = rsp_last_ff;

endmodule

// ===== sim/eller_maze_row_generator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eller_maze_row_generator_unit_test
// Self-checking bench: drives random and directed row beats under several
// row/column settings, predicts each row and compares every response beat.
// ----------------------------------------------------------------------------
module eller_maze_row_generator_unit_test;
   import emr_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] right_walls;
      logic [DATA_W-1:0] bottom_walls;
      logic              last_row;
   } row_walls_type;

   class row_scoreboard_type;
      logic [CSR_W-1:0]  rows_reg;
      logic [CSR_W-1:0]  cols_reg;
      logic [LBL_W-1:0]  labels[64];
      logic [DATA_W-1:0] prev_bottom;
      logic [LBL_W-1:0]  next_lbl;
      int                row_idx;
      row_walls_type     pending[$];
      int                errors;

      function void new_maze();
         foreach (labels[i]) labels[i] = '0;
         prev_bottom = '0;
         next_lbl = LBL_W'(1);
         row_idx = 0;
      endfunction

      function new();
         rows_reg = ROW_COUNT_RST;
         cols_reg = COL_COUNT_RST;
         errors = 0;
         new_maze();
      endfunction

      function void join_sets(int n, int keep, int drop);
         logic [LBL_W-1:0] to_l, from_l;
         to_l = labels[keep];
         from_l = labels[drop];
         for (int j = 0; j < n; j++)
            if (labels[j] == from_l) labels[j] = to_l;
      endfunction

      function void note_row(logic [DATA_W-1:0] rr, logic [DATA_W-1:0] br);
         int n, rows, open_cnt;
         bit fin;
         row_walls_type w;
         rows = rows_reg < 2 ? 2 : (rows_reg > 64 ? 64 : rows_reg);
         n = cols_reg < 1 ? 1 : (cols_reg > 64 ? 64 : cols_reg);
         fin = (row_idx + 1 >= rows);
         for (int i = 0; i < n; i++) begin
            if (row_idx == 0 ? labels[i] == 0 : prev_bottom[i]) begin
               labels[i] = next_lbl;
               next_lbl = next_lbl + 1'b1;
            end
         end
         w = '0;
         for (int i = 0; i + 1 < n; i++) begin
            if (rr[i] || labels[i] == labels[i+1]) w.right_walls[i] = 1'b1;
            else join_sets(n, i, i + 1);
         end
         w.right_walls[n-1] = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (!br[i]) continue;
            open_cnt = 0;
            for (int j = 0; j < n; j++)
               if (labels[j] == labels[i] && !w.bottom_walls[j]) open_cnt++;
            if (open_cnt > 1) w.bottom_walls[i] = 1'b1;
         end
         if (fin) begin
            for (int i = 0; i + 1 < n; i++) begin
               if (labels[i] != labels[i+1]) w.right_walls[i] = 1'b0;
               join_sets(n, i, i + 1);
            end
            w.right_walls[n-1] = 1'b1;
            w.bottom_walls = '0;
            for (int i = 0; i < n; i++) w.bottom_walls[i] = 1'b1;
         end
         w.last_row = fin;
         pending.insert(pending.size(), w);
         if (fin) new_maze();
         else begin
            prev_bottom = w.bottom_walls;
            row_idx++;
         end
      endfunction

      function void check_row(row_walls_type got);
         row_walls_type exp_w;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat %h", got);
            return;
         end
         exp_w = pending.pop_front();
         if (got !== exp_w) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp r=%h b=%h l=%b  got r=%h b=%h l=%b",
                  exp_w.right_walls, exp_w.bottom_walls, exp_w.last_row,
                  got.right_walls, got.bottom_walls, got.last_row);
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic [DATA_W-1:0] req_right_random = '0;
   logic [DATA_W-1:0] req_bottom_random = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic [DATA_W-1:0] rsp_right_walls;
   logic [DATA_W-1:0] rsp_bottom_walls;
   logic              rsp_last_row;
   logic              csr_we = 0;
   reg_idx_type       csr_index = REG_ROW_COUNT;
   logic [CSR_W-1:0]  csr_wdata = '0;

   row_scoreboard_type sb = new();
   int  idle_cycles = 0;
   bit  long_hold = 0;
   bit  stall_rand = 1;

   eller_maze_row_generator_unit dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) idle_cycles <= 0;
      else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 200000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_row({rsp_right_walls, rsp_bottom_walls, rsp_last_row});
   end

   function int gap_len();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
   endfunction

   // receiver idling, with one long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 0;
         end else if (stall_rand && $urandom_range(0, 3) == 0) begin
            n = gap_len();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   task automatic send_row(logic [DATA_W-1:0] rr, logic [DATA_W-1:0] br);
      @(posedge clock);
      req_valid <= 1'b1;
      req_right_random <= rr;
      req_bottom_random <= br;
      do @(posedge clock); while (req_stall);
      sb.note_row(rr, br);
      req_valid <= 1'b0;
   endtask

   task automatic send_gap_row(logic [DATA_W-1:0] rr, logic [DATA_W-1:0] br);
      if ($urandom_range(0, 2) == 0) repeat (gap_len()) @(posedge clock);
      send_row(rr, br);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, logic [CSR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_ROW_COUNT) sb.rows_reg = val;
      else sb.cols_reg = val;
   endtask

   function logic [DATA_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function logic [DATA_W-1:0] biased64();
      case ($urandom_range(0, 3))
         0: return rand64() & rand64();
         1: return rand64() | rand64();
         default: return rand64();
      endcase
   endfunction

   initial begin
      logic [CSR_W-1:0] rows_set[8];
      logic [CSR_W-1:0] cols_set[8];
      rows_set = '{7'd2, 7'd64, 7'd5, 7'd3, 7'd0, 7'd127, 7'd10, 7'd4};
      cols_set = '{7'd64, 7'd1, 7'd8, 7'd2, 7'd0, 7'd127, 7'd33, 7'd5};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: default 2x64 maze, extremes of the random words
      send_row('0, '0);
      send_row('1, '1);
      send_row('1, '0);
      send_row('0, '1);
      send_row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      send_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      drain();
      write_reg(REG_ROW_COUNT, 7'd4);
      write_reg(REG_COL_COUNT, 7'd1);
      for (int i = 0; i < 4; i++) send_row('1, '1);
      drain();
      write_reg(REG_COL_COUNT, 7'd6);
      for (int i = 0; i < 6; i++) send_row(rand64(), '1);
      drain();
      // mid-maze shrink of rows and growth of columns
      write_reg(REG_ROW_COUNT, 7'd8);
      send_row(rand64(), rand64());
      send_row(rand64(), rand64());
      send_row(rand64(), rand64());
      drain();
      write_reg(REG_ROW_COUNT, 7'd2);
      write_reg(REG_COL_COUNT, 7'd12);
      send_row(rand64(), rand64());
      drain();
      // random phases
      for (int p = 0; p < 8; p++) begin
         write_reg(REG_ROW_COUNT, rows_set[p]);
         write_reg(REG_COL_COUNT, cols_set[p]);
         if (p == 2) long_hold = 1;
         for (int k = 0; k < 100; k++) begin
            if (p == 5 && k == 50) drain();
            send_gap_row(biased64(), biased64());
         end
         drain();
      end
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule
